@@ rtl/mrfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfr_pkg
// Shared types, constants and the CRC-16/Modbus byte fold for the Modbus RTU
// response frame receiver.
// ----------------------------------------------------------------------------
package mrfr_pkg;

  // Frame position counter: address, function, count, up to 255 data, 2 CRC
  localparam int unsigned POS_W = 9;

  localparam logic [POS_W-1:0] POS_ADDR  = 9'd0;
  localparam logic [POS_W-1:0] POS_FUNC  = 9'd1;
  localparam logic [POS_W-1:0] POS_COUNT = 9'd2;
  localparam logic [POS_W-1:0] POS_DATA0 = 9'd3;
  localparam logic [POS_W-1:0] POS_DATA1 = 9'd4;

  // Offset of the first CRC byte past the declared data count
  localparam logic [POS_W-1:0] HDR_LEN   = 9'd3;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_RESET = 8'h03;

  // One result item
  typedef struct packed {
    logic        byte_taken;
    logic        frame_ok;
    logic        crc_error;
    logic [7:0]  slave_address;
    logic [7:0]  byte_count;
    logic [15:0] first_word;
  } result_t;

  // Fold one byte into a CRC-16/Modbus (reflected, LSB first)
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

@@ rtl/modbus_response_frame_receiver_top.sv @@
// Path: the input byte is registered in the input reg, its result in the result reg.
// Throughput: one byte per cycle while the result is not stalled;
// both registers load and unload in the same cycle.
// A stalled result holds both registers and in_stall rises once the input reg is full.
// Reset (rst_n low, synchronous): receiver idle waiting for an address byte,
// CRC preset to 0xFFFF, expected function code 0x03, both registers empty.
// ----------------------------------------------------------------------------
// modbus_response_frame_receiver_top
// Modbus RTU read-response receiver: input register, frame decoder with
// on-the-fly CRC-16/Modbus check, result register.
// ----------------------------------------------------------------------------
module modbus_response_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_taken,
  output logic        out_frame_ok,
  output logic        out_crc_error,
  output logic [7:0]  out_slave_address,
  output logic [7:0]  out_byte_count,
  output logic [15:0] out_first_word
);

  logic              cfg_xfer;
  logic [7:0]        exp_func_r;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r;
  mrfr_pkg::result_t out_r;
  mrfr_pkg::result_t result;
  logic              out_free;
  logic              step;
  logic              in_xfer;

  // Config register, always writable
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_func_r <= mrfr_pkg::FUNC_RESET;
    end else if (cfg_xfer) begin
      exp_func_r <= cfg_data;
    end
  end

  // Pipeline flow control
  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  mrfr_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (step),
    .rx_byte           (s1_byte_r),
    .expected_function (exp_func_r),
    .result            (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_taken    = out_r.byte_taken;
  assign out_frame_ok      = out_r.frame_ok;
  assign out_crc_error     = out_r.crc_error;
  assign out_slave_address = out_r.slave_address;
  assign out_byte_count    = out_r.byte_count;
  assign out_first_word    = out_r.first_word;

endmodule

@@ rtl/mrfr_parser.sv @@
// ----------------------------------------------------------------------------
// mrfr_parser
// Frame state and per-byte decode. Computes the result for the byte held in
// the input register and commits the frame state when that byte moves on.
// ----------------------------------------------------------------------------
module mrfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          expected_function,
  output mrfr_pkg::result_t   result
);

  logic [mrfr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [7:0]                 addr_r, addr_nxt;
  logic [15:0]                word_r, word_nxt;
  logic [7:0]                 crc_lo_r, crc_lo_nxt;

  logic [mrfr_pkg::POS_W-1:0] crc_pos;
  logic [15:0]                crc_folded;
  logic                       taken;
  logic                       ok;
  logic                       err;
  logic [7:0]                 count_out;

  // Position of the low CRC byte for the current frame
  assign crc_pos    = {1'b0, len_r} + mrfr_pkg::HDR_LEN;
  assign crc_folded = mrfr_pkg::crc_fold(crc_r, rx_byte);

  // Per-byte decode
  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    addr_nxt   = addr_r;
    word_nxt   = word_r;
    crc_lo_nxt = crc_lo_r;
    taken      = 1'b1;
    ok         = 1'b0;
    err        = 1'b0;

    if (pos_r == mrfr_pkg::POS_ADDR) begin
      addr_nxt = rx_byte;
      word_nxt = '0;
      crc_nxt  = mrfr_pkg::crc_fold(mrfr_pkg::CRC_INIT, rx_byte);
      pos_nxt  = mrfr_pkg::POS_FUNC;
    end else if (pos_r == mrfr_pkg::POS_FUNC) begin
      // wrong function code is dropped, keep waiting
      if (rx_byte == expected_function) begin
        crc_nxt = crc_folded;
        pos_nxt = mrfr_pkg::POS_COUNT;
      end else begin
        taken = 1'b0;
      end
    end else if (pos_r == mrfr_pkg::POS_COUNT) begin
      len_nxt = rx_byte;
      crc_nxt = crc_folded;
      pos_nxt = mrfr_pkg::POS_DATA0;
    end else if (pos_r < crc_pos) begin
      if (pos_r == mrfr_pkg::POS_DATA0) begin
        word_nxt = {rx_byte, 8'h00};
      end else if (pos_r == mrfr_pkg::POS_DATA1) begin
        word_nxt = {word_r[15:8], rx_byte};
      end
      crc_nxt = crc_folded;
      pos_nxt = pos_r + 9'd1;
    end else if (pos_r == crc_pos) begin
      crc_lo_nxt = rx_byte;
      pos_nxt    = pos_r + 9'd1;
    end else begin
      // high CRC byte: compare against the running CRC
      if ({rx_byte, crc_lo_r} == crc_r) begin
        ok = 1'b1;
      end else begin
        err = 1'b1;
      end
    end

    count_out = len_nxt;

    // frame done: back to idle
    if (ok || err) begin
      pos_nxt = mrfr_pkg::POS_ADDR;
      len_nxt = '0;
      crc_nxt = mrfr_pkg::CRC_INIT;
    end
  end

  // Result for the byte in the input register
  always_comb begin
    result.byte_taken    = taken;
    result.frame_ok      = ok;
    result.crc_error     = err;
    result.slave_address = addr_nxt;
    result.byte_count    = count_out;
    result.first_word    = word_nxt;
  end

  // Frame state commits on each transfer into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= mrfr_pkg::POS_ADDR;
      len_r    <= '0;
      crc_r    <= mrfr_pkg::CRC_INIT;
      addr_r   <= '0;
      word_r   <= '0;
      crc_lo_r <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      addr_r   <= addr_nxt;
      word_r   <= word_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule
